FILE: rtl/ctt_pkg.sv
// ----------------------------------------------------------------------------
// ctt_pkg
// Shared widths, codes and types of the connection table with timeout.
// ----------------------------------------------------------------------------
package ctt_pkg;

    localparam int ID_W       = 16;
    localparam int TIME_W     = 32;
    localparam int TICK_W     = 16;
    localparam int CMD_W      = 2;
    localparam int CAP_W      = 5;
    localparam int TMO_W      = 16;
    localparam int CNT_OUT_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CMD_W-1:0] CMD_CONNECT    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISCONNECT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 1'd1;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [TMO_W-1:0]  TMO_RESET = 16'd100;
    localparam logic [TIME_W-1:0] TIME_MAX  = '1;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic [CAP_W-1:0] capacity;
        logic [TMO_W-1:0] timeout;
    } cfg_t;

    typedef struct packed {
        logic                 ok;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [TIME_W-1:0]    current_time;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

endpackage

FILE: rtl/connection_table_with_timeout.sv
// ----------------------------------------------------------------------------
// connection_table_with_timeout
// Ordered table of device connections with append, remove by id and
// time-based expiry; one result transfer for every command transfer.
//
// channel   direction  contents
// s_*       in         command transfer: tuser command, tdata id and ticks
// m_*       out        result transfer: ok, entry count, current time
// cfg_*     in         register write: capacity, timeout
//
// connect and unused commands go from idle straight to emit, then to the output register.
// disconnect and advance walk the whole table through the single read port
// of the entry memory, one entry per cycle.
// reset clears count and time at once; the entry memory needs no clearing.
// a new command is taken while the previous result waits in the output
// register; a stalled result holds the engine before it emits the next one.
// ----------------------------------------------------------------------------
module connection_table_with_timeout #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // device_id, tick_count
    input  logic [1:0]                      s_tuser,   // command
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,   // ok, entry_count, current_time
    input  logic                            cfg_we,
    input  logic [ctt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ctt_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ctt_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int RES_W = 1 + CNT_OUT_W + TIME_W;

    logic [CAP_W-1:0]  capacity_reg;
    logic [TMO_W-1:0]  timeout_reg;
    cfg_t              cfg;

    logic              res_valid;
    logic              res_ready;
    result_t           res;
    logic              m_tvalid_reg;
    logic [RES_W-1:0]  m_data_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_rdata;

    assign cfg = '{capacity: capacity_reg, timeout: timeout_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            timeout_reg  <= TMO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                REG_TIMEOUT:  timeout_reg  <= cfg_data[TMO_W-1:0];
                default:      ;
            endcase
        end
    end

    ctt_engine #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_id     (s_tdata[15:0]),
        .in_ticks  (s_tdata[31:16]),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ctt_ram #(
        .DEPTH  (MAX_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_data_reg <= {res.current_time, res.entry_count, res.ok};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(40 - RES_W)'(0), m_data_reg};

endmodule

FILE: rtl/ctt_ram.sv
// ----------------------------------------------------------------------------
// ctt_ram
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  ctt_pkg::entry_t     wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output ctt_pkg::entry_t     rdata
);
    import ctt_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/ctt_engine.sv
// ----------------------------------------------------------------------------
// ctt_engine
// Command sequencer: appends on connect, and on disconnect or advance walks
// the table through the entry memory, compacting survivors in place.
// ----------------------------------------------------------------------------
module ctt_engine #(
    parameter int MAX_ENTRIES = 16,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ctt_pkg::CMD_W-1:0]   in_cmd,
    input  logic [ctt_pkg::ID_W-1:0]    in_id,
    input  logic [ctt_pkg::TICK_W-1:0]  in_ticks,
    input  ctt_pkg::cfg_t               cfg,
    output logic                        res_valid,
    input  logic                        res_ready,
    output ctt_pkg::result_t            res,
    output logic                        ram_we,
    output logic [IDX_W-1:0]            ram_waddr,
    output ctt_pkg::entry_t             ram_wdata,
    output logic                        ram_re,
    output logic [IDX_W-1:0]            ram_raddr,
    input  ctt_pkg::entry_t             ram_rdata
);
    import ctt_pkg::*;

    localparam int EXT_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]  now_reg, now_next;
    logic [CNT_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;
    logic               found_reg, found_next;
    logic               tick_reg, tick_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic               ok_reg, ok_next;

    logic [EXT_W-1:0]   count_ext;
    logic               can_connect;
    logic [TIME_W:0]    now_sum;
    logic [TIME_W-1:0]  now_sat;
    logic [TIME_W:0]    due;
    logic               expired;
    logic               drop;

    assign count_ext   = EXT_W'(count_reg);
    assign can_connect = (count_ext < EXT_W'(cfg.capacity))
                      && (count_reg < CNT_W'(MAX_ENTRIES));
    assign now_sum     = {1'b0, now_reg} + (TIME_W + 1)'(in_ticks);
    assign now_sat     = now_sum[TIME_W] ? TIME_MAX : now_sum[TIME_W-1:0];
    assign due         = {1'b0, ram_rdata.stamp} + (TIME_W + 1)'(cfg.timeout);
    assign expired     = (due <= {1'b0, now_reg});
    assign drop        = tick_reg ? expired : (!found_reg && (ram_rdata.id == id_reg));

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_EMIT);
    assign res       = '{ok: ok_reg, entry_count: count_ext[CNT_OUT_W-1:0],
                         current_time: now_reg};

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        now_next     = now_reg;
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        rd_pend_next = rd_pend_reg;
        rd_last_next = rd_last_reg;
        found_next   = found_reg;
        tick_next    = tick_reg;
        id_next      = id_reg;
        ok_next      = ok_reg;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[IDX_W-1:0];
        ram_wdata    = '{id: in_id, stamp: now_reg};
        ram_re       = 1'b0;
        ram_raddr    = rd_ptr_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    id_next      = in_id;
                    tick_next    = (in_cmd == CMD_TICK);
                    rd_ptr_next  = '0;
                    wr_ptr_next  = '0;
                    rd_pend_next = 1'b0;
                    rd_last_next = 1'b0;
                    found_next   = 1'b0;
                    state_next   = ST_EMIT;
                    case (in_cmd)
                        CMD_CONNECT:
                        begin
                            ok_next = can_connect;
                            if (can_connect)
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DISCONNECT:
                        begin
                            ok_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_TICK:
                        begin
                            ok_next  = 1'b1;
                            now_next = now_sat;
                            if (count_reg != '0)
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = 1'b0;
                if (rd_ptr_reg < count_reg)
                begin
                    ram_re       = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + CNT_W'(1);
                    rd_pend_next = 1'b1;
                    rd_last_next = (rd_ptr_reg == count_reg - CNT_W'(1));
                end
                if (rd_pend_reg)
                begin
                    // survivors move down to the write pointer
                    if (!drop)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = wr_ptr_reg[IDX_W-1:0];
                        ram_wdata   = ram_rdata;
                        wr_ptr_next = wr_ptr_reg + CNT_W'(1);
                    end
                    else if (!tick_reg)
                    begin
                        found_next = 1'b1;
                    end
                    if (rd_last_reg)
                    begin
                        count_next = drop ? wr_ptr_reg : wr_ptr_reg + CNT_W'(1);
                        if (!tick_reg)
                        begin
                            ok_next = found_reg || drop;
                        end
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            now_reg     <= '0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            now_reg     <= now_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        wr_ptr_reg  <= wr_ptr_next;
        rd_last_reg <= rd_last_next;
        found_reg   <= found_next;
        tick_reg    <= tick_next;
        id_reg      <= id_next;
        ok_reg      <= ok_next;
    end

endmodule
